// File: design/abd_pkg.sv
package abd_pkg;

   // field widths
   localparam int unsigned ByteW   = 8;
   localparam int unsigned NibW    = 4;
   localparam int unsigned PosW    = 4;
   localparam int unsigned SampW   = 32;
   localparam int unsigned CoefW   = 8;
   localparam int unsigned ProdW   = SampW + CoefW;
   localparam int unsigned PredSh  = 6;
   localparam int unsigned TermW   = ProdW - PredSh;
   localparam int unsigned AccW    = TermW + 2;
   localparam int unsigned BaseW   = 16;
   localparam int unsigned UserOutW = 3;

   // byte positions inside a block
   localparam logic [PosW-1:0] PosHead  = 4'd0;
   localparam logic [PosW-1:0] PosFlags = 4'd1;
   localparam logic [PosW-1:0] PosLast  = 4'd15;

   // flags value that means jump to the loop start
   localparam logic [ByteW-1:0] FlagsJump = 8'd3;

   // end action codes
   localparam logic [1:0] EndContinue = 2'd0;
   localparam logic [1:0] EndJump     = 2'd1;
   localparam logic [1:0] EndStop     = 2'd2;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic mul_a;
      logic mul_b;
      logic finish;
      logic nib_sel;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic header;
      logic out_free;
   } sts_type;

   // first-tap coefficient; unknown filters behave as filter 0
   function automatic logic signed [CoefW-1:0] coef_a(input logic [NibW-1:0] f);
      logic signed [CoefW-1:0] c;
      case (f)
         4'd1:    c = 8'sd60;
         4'd2:    c = 8'sd115;
         4'd3:    c = 8'sd98;
         4'd4:    c = 8'sd122;
         default: c = 8'sd0;
      endcase
      return c;
   endfunction

   // second-tap coefficient
   function automatic logic signed [CoefW-1:0] coef_b(input logic [NibW-1:0] f);
      logic signed [CoefW-1:0] c;
      case (f)
         4'd2:    c = -8'sd52;
         4'd3:    c = -8'sd55;
         4'd4:    c = -8'sd60;
         default: c = 8'sd0;
      endcase
      return c;
   endfunction

endpackage

// File: design/abd_ctrl.sv
module abd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  abd_pkg::sts_type sts,
   output abd_pkg::cmd_type cmd
);
   import abd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_SUM
   } state_type;

   state_type state_ff, state_in;
   logic      nib_ff, nib_in;

   // next state
   always_comb begin
      state_in = state_ff;
      nib_in   = nib_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && !sts.header) begin
               state_in = ST_MUL_A;
               nib_in   = 1'b0;
            end
         end
         ST_MUL_A: state_in = ST_MUL_B;
         ST_MUL_B: state_in = ST_SUM;
         ST_SUM: begin
            // wait here until the output register can take the sample
            if (sts.out_free) begin
               if (!nib_ff) begin
                  state_in = ST_MUL_A;
                  nib_in   = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         nib_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         nib_ff   <= nib_in;
      end
   end

   // commands
   always_comb begin
      req_tready  = (state_ff == ST_IDLE);
      cmd.load    = req_tvalid && (state_ff == ST_IDLE);
      cmd.mul_a   = (state_ff == ST_MUL_A);
      cmd.mul_b   = (state_ff == ST_MUL_B);
      cmd.finish  = (state_ff == ST_SUM) && sts.out_free;
      cmd.nib_sel = nib_ff;
   end

endmodule

// File: design/abd_datapath.sv
module abd_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  abd_pkg::cmd_type                  cmd,
   output abd_pkg::sts_type                  sts,
   input  logic                              req_tuser,
   input  logic [abd_pkg::ByteW-1:0]         req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [abd_pkg::SampW-1:0]         rsp_tdata,
   output logic                              rsp_tlast,
   output logic [abd_pkg::UserOutW-1:0]      rsp_tuser
);
   import abd_pkg::*;

   logic signed [SampW-1:0] hist1_ff, hist1_in;
   logic signed [SampW-1:0] hist2_ff, hist2_in;
   logic [PosW-1:0]         pos_ff, pos_in;
   logic [NibW-1:0]         shift_ff, shift_in;
   logic [NibW-1:0]         filter_ff, filter_in;
   logic [ByteW-1:0]        flags_ff, flags_in;
   logic [ByteW-1:0]        byte_ff, byte_in;
   logic                    last_ff, last_in;
   logic signed [ProdW-1:0] prod_ff, prod_in;
   logic signed [AccW-1:0]  acc_ff, acc_in;
   logic                    out_valid_ff, out_valid_in;
   logic [SampW-1:0]        out_data_ff, out_data_in;
   logic                    out_last_ff, out_last_in;
   logic [UserOutW-1:0]     out_user_ff, out_user_in;

   logic [PosW-1:0]         pos_cur;
   logic [NibW-1:0]         nib;
   logic signed [BaseW-1:0] base;
   logic signed [SampW-1:0] mul_x;
   logic signed [CoefW-1:0] mul_c;
   logic signed [TermW-1:0] term;
   logic signed [AccW-1:0]  sum;
   logic signed [SampW-1:0] sat;
   logic                    out_free;
   logic                    is_last;
   logic [1:0]              end_code;

   // position of the byte now offered; restart starts a new block
   assign pos_cur = req_tuser ? PosHead : pos_ff;
   assign out_free = !out_valid_ff || rsp_tready;
   assign sts.header   = (pos_cur == PosHead) || (pos_cur == PosFlags);
   assign sts.out_free = out_free;

   // nibble in bits 15..12, then arithmetic shift
   assign nib  = cmd.nib_sel ? byte_ff[ByteW-1:NibW] : byte_ff[NibW-1:0];
   assign base = $signed({nib, 12'b0}) >>> shift_ff;

   // shared multiplier: first tap, then second tap
   assign mul_x = cmd.mul_b ? hist2_ff : hist1_ff;
   assign mul_c = cmd.mul_b ? coef_b(filter_ff) : coef_a(filter_ff);
   assign term  = TermW'(prod_ff >>> PredSh);

   // final sum and saturation to 32 bits
   always_comb begin
      sum = acc_ff + AccW'(term);
      if (sum > AccW'(signed'({1'b0, {(SampW-1){1'b1}}}))) begin
         sat = {1'b0, {(SampW-1){1'b1}}};
      end else if (sum < -AccW'(signed'({1'b0, {(SampW-1){1'b1}}})) - AccW'(1)) begin
         sat = {1'b1, {(SampW-1){1'b0}}};
      end else begin
         sat = sum[SampW-1:0];
      end
   end

   // block end marks, only on the high nibble of the last byte
   always_comb begin
      is_last  = cmd.nib_sel && last_ff;
      end_code = EndContinue;
      if (is_last && flags_ff[0]) begin
         end_code = (flags_ff == FlagsJump) ? EndJump : EndStop;
      end
   end

   // next values
   always_comb begin
      hist1_in     = hist1_ff;
      hist2_in     = hist2_ff;
      pos_in       = pos_ff;
      shift_in     = shift_ff;
      filter_in    = filter_ff;
      flags_in     = flags_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_user_in  = out_user_ff;

      if (cmd.load) begin
         if (req_tuser) begin
            hist1_in = '0;
            hist2_in = '0;
         end
         pos_in  = pos_cur + PosW'(1);
         byte_in = req_tdata;
         last_in = (pos_cur == PosLast);
         if (pos_cur == PosHead) begin
            shift_in  = req_tdata[NibW-1:0];
            filter_in = req_tdata[ByteW-1:NibW];
         end
         if (pos_cur == PosFlags) begin
            flags_in = req_tdata;
         end
      end

      if (cmd.mul_a || cmd.mul_b) begin
         prod_in = ProdW'(mul_x) * ProdW'(mul_c);
      end
      if (cmd.mul_b) begin
         acc_in = AccW'(base) + AccW'(term);
      end

      if (cmd.finish) begin
         hist2_in     = hist1_ff;
         hist1_in     = sat;
         out_valid_in = 1'b1;
         out_data_in  = sat;
         out_last_in  = is_last;
         out_user_in  = {end_code, is_last && flags_ff[2]};
      end
   end

   // control and history registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hist1_ff     <= '0;
         hist2_ff     <= '0;
         pos_ff       <= '0;
         shift_ff     <= '0;
         filter_ff    <= '0;
         flags_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         hist1_ff     <= hist1_in;
         hist2_ff     <= hist2_in;
         pos_ff       <= pos_in;
         shift_ff     <= shift_in;
         filter_ff    <= filter_in;
         flags_ff     <= flags_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // working and output payload registers
   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      out_user_ff <= out_user_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

// File: design/adpcm_block_decoder_top.sv
// ADPCM block decoder: takes 16-byte sound blocks one byte per item and returns
// two 32-bit samples for each data byte (low nibble first). The two header bytes
// (shift/filter, then flags) are taken while idle and give no item. Each
// sample of a data byte steps through MUL_A, MUL_B and SUM, since both
// prediction taps go through one shared 32x8 multiplier before the saturating
// sum; a sample held back by the result side stalls the work. The next byte is
// taken while the second sample still waits in the output register. A restart
// flag on an input item clears the history and makes that byte the block header.
module adpcm_block_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // sample
   output logic        rsp_tlast,   // last_of_block
   output logic [2:0]  rsp_tuser    // loop_start_mark, end_action[1:0]
);
   import abd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   abd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   abd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // end marks only ride on the last sample of a block
   a_marks_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser == '0)
      else $error("end marks outside the last sample");

   // a finished sample shows up in the output register
   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_tvalid)
      else $error("finished sample not presented");

   // header bytes do not stall the input
   a_header_quick: assert property (@(posedge clock) disable iff (reset)
      cmd.load && sts.header |=> req_tready)
      else $error("header byte stalled the input");

endmodule

// File: verif/adpcm_sample_pkg.sv
`timescale 1ns / 100ps
package adpcm_sample_pkg;
   import abd_pkg::*;

   // one expected decoded sample with its block-end markers
   typedef struct {
      logic signed [SampW-1:0] sample;
      logic                    last;
      logic                    loop_mark;
      logic [1:0]              end_act;
   } sample_item_type;

   localparam longint SampMax = 64'sd2147483647;
   localparam longint SampMin = -64'sd2147483648;

   // tracks decoder state per accepted byte and queues the samples it must produce
   class adpcm_sample_tracker;
      logic signed [SampW-1:0] hist_one;
      logic signed [SampW-1:0] hist_two;
      logic [PosW-1:0]         position;
      logic [NibW-1:0]         shift;
      logic [NibW-1:0]         filter;
      logic [ByteW-1:0]        flags;
      sample_item_type         pending_samples[$];
      int unsigned             error_count;

      function new();
         hist_one    = '0;
         hist_two    = '0;
         position    = PosHead;
         shift       = '0;
         filter      = '0;
         flags       = '0;
         error_count = 0;
      endfunction

      // nibble scaled, shifted, plus two-tap prediction, saturated to 32 bits
      function logic signed [SampW-1:0] decode_nibble(logic [NibW-1:0] nib);
         longint                  base;
         longint                  ca;
         longint                  cb;
         longint                  sum;
         logic signed [SampW-1:0] result;
         base = longint'($signed({nib, 12'h000}));
         // filters above four fall back to no prediction
         case (filter)
            4'd1: begin
               ca = 60;
               cb = 0;
            end
            4'd2: begin
               ca = 115;
               cb = -52;
            end
            4'd3: begin
               ca = 98;
               cb = -55;
            end
            4'd4: begin
               ca = 122;
               cb = -60;
            end
            default: begin
               ca = 0;
               cb = 0;
            end
         endcase
         sum = (base >>> shift)
             + ((longint'(hist_one) * ca) >>> PredSh)
             + ((longint'(hist_two) * cb) >>> PredSh);
         if (sum > SampMax) begin
            result = SampMax[SampW-1:0];
         end else if (sum < SampMin) begin
            result = SampMin[SampW-1:0];
         end else begin
            result = sum[SampW-1:0];
         end
         hist_two = hist_one;
         hist_one = result;
         return result;
      endfunction

      // one accepted input byte: header, flags or two samples
      function void note_byte(logic restart, logic [ByteW-1:0] data);
         logic [PosW-1:0] here;
         logic            at_end;
         sample_item_type first;
         sample_item_type second;
         if (restart) begin
            hist_one = '0;
            hist_two = '0;
            position = PosHead;
         end
         here     = position;
         position = position + PosW'(1);
         if (here == PosHead) begin
            shift  = data[3:0];
            filter = data[7:4];
         end else if (here == PosFlags) begin
            flags = data;
         end else begin
            at_end           = (here == PosLast);
            first.sample     = decode_nibble(data[3:0]);
            first.last       = 1'b0;
            first.loop_mark  = 1'b0;
            first.end_act    = EndContinue;
            second.sample    = decode_nibble(data[7:4]);
            second.last      = at_end;
            second.loop_mark = at_end & flags[2];
            if (at_end && flags[0]) begin
               second.end_act = (flags == FlagsJump) ? EndJump : EndStop;
            end else begin
               second.end_act = EndContinue;
            end
            pending_samples.push_back(first);
            pending_samples.push_back(second);
         end
      endfunction

      // compare a delivered sample with the oldest one waiting
      function void check_sample(logic [SampW-1:0] sample, logic last, logic loop_mark,
                                 logic [1:0] end_act);
         sample_item_type want;
         if (pending_samples.size() == 0) begin
            $error("unexpected item: sample %0d", $signed(sample));
            error_count++;
            return;
         end
         want = pending_samples.pop_front();
         if (sample !== want.sample) begin
            $error("sample: expected %0d, got %0d", want.sample, $signed(sample));
            error_count++;
         end
         if (last !== want.last) begin
            $error("last_of_block: expected %0d, got %0d", want.last, last);
            error_count++;
         end
         if (loop_mark !== want.loop_mark) begin
            $error("loop_start_mark: expected %0d, got %0d", want.loop_mark, loop_mark);
            error_count++;
         end
         if (end_act !== want.end_act) begin
            $error("end_action: expected %0d, got %0d", want.end_act, end_act);
            error_count++;
         end
      endfunction

      function int unsigned outstanding();
         return pending_samples.size();
      endfunction
   endclass

endpackage

// File: verif/tb_adpcm_block_decoder_top.sv
`timescale 1ns / 100ps
module tb_adpcm_block_decoder_top;
   import abd_pkg::*;
   import adpcm_sample_pkg::*;

   localparam int unsigned CycleLimit  = 600000;
   localparam int unsigned RandomBytes = 1000;
   localparam int unsigned DrainCycles = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // data_byte
   logic        req_tuser = 1'b0;    // restart
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // sample
   logic        rsp_tlast;           // last_of_block
   logic [2:0]  rsp_tuser;           // loop_start_mark, end_action[1:0]

   adpcm_sample_tracker tracker;
   int unsigned         cycle_count = 0;
   bit                  calm = 1'b0;

   adpcm_block_decoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // mostly short gaps, a few long ones, none while calm
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // enter and leave on a falling edge; valid stays high across back-to-back items
   task automatic send_byte(input logic restart, input logic [7:0] data);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= restart;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // extreme nibbles, filter fallback, large shifts and restart mid-block
   task automatic run_directed();
      send_byte(1'b1, 8'h40);
      send_byte(1'b0, 8'h03);
      send_byte(1'b0, 8'h00);
      send_byte(1'b0, 8'hFF);
      send_byte(1'b0, 8'h88);
      send_byte(1'b0, 8'h77);
      send_byte(1'b0, 8'h80);
      send_byte(1'b0, 8'h08);
      send_byte(1'b0, 8'h7F);
      send_byte(1'b0, 8'hF7);
      send_byte(1'b0, 8'h11);
      send_byte(1'b0, 8'hEE);
      send_byte(1'b0, 8'h8F);
      send_byte(1'b0, 8'hF8);
      send_byte(1'b0, 8'h70);
      send_byte(1'b0, 8'h07);
      send_byte(1'b1, 8'h5F);
      send_byte(1'b0, 8'h05);
      send_byte(1'b0, 8'h88);
      send_byte(1'b0, 8'h7F);
      send_byte(1'b1, 8'hFD);
      send_byte(1'b0, 8'h01);
      send_byte(1'b0, 8'h88);
      send_byte(1'b0, 8'hFF);
   endtask

   // whole blocks with random content, some cut short or broken by a restart
   task automatic run_random();
      int unsigned sent;
      int unsigned body_len;
      bit          force_restart;
      bit          loud;
      bit          head_restart;
      bit          broken;
      logic [3:0]  filt;
      logic [3:0]  shamt;
      logic [7:0]  flag_byte;
      logic [7:0]  data;
      sent          = 0;
      force_restart = 1'b0;
      while (sent < RandomBytes) begin
         head_restart = force_restart || ($urandom_range(0, 3) == 0);
         loud         = ($urandom_range(0, 7) == 0);
         calm         = ($urandom_range(0, 4) == 0);
         broken       = ($urandom_range(0, 9) == 0);
         // loud blocks drive the strongest filter hard to push the history up
         if (loud) begin
            filt  = 4'd4;
            shamt = 4'd0;
         end else begin
            filt  = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, 4))
                                                 : 4'($urandom_range(5, 15));
            shamt = 4'($urandom_range(0, 15));
         end
         flag_byte = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7))
                                                : 8'($urandom_range(0, 255));
         body_len      = broken ? $urandom_range(0, 13) : 14;
         force_restart = broken && ($urandom_range(0, 1) == 1);
         send_byte(head_restart, {filt, shamt});
         send_byte(($urandom_range(0, 49) == 0), flag_byte);
         for (int unsigned i = 0; i < body_len; i++) begin
            if (loud) begin
               data = ($urandom_range(0, 1) == 1) ? 8'h88 : 8'h77;
            end else begin
               data = 8'($urandom_range(0, 255));
            end
            send_byte(($urandom_range(0, 49) == 0), data);
         end
         sent += 2 + body_len;
      end
      calm = 1'b0;
   endtask

   // stimulus, drain and verdict
   initial begin
      tracker = new();
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      run_directed();
      run_random();
      req_tvalid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (tracker.error_count == 0) begin
         $display("[adpcm_block_decoder_top] OK");
      end else begin
         $display("[adpcm_block_decoder_top] ERROR");
      end
      $finish;
   end

   // result-side back-pressure: free-running stretches or short bursts with stalls
   initial begin
      int unsigned r;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         r = $urandom_range(0, 99);
         rsp_tready <= 1'b1;
         if (r < 15) begin
            repeat ($urandom_range(50, 200)) @(negedge clock);
         end else begin
            repeat ($urandom_range(1, 8)) @(negedge clock);
            rsp_tready <= 1'b0;
            if (r < 85) begin
               repeat ($urandom_range(1, 3)) @(negedge clock);
            end else begin
               repeat ($urandom_range(10, 40)) @(negedge clock);
            end
         end
      end
   end

   // handshake monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            tracker.note_byte(req_tuser, req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            tracker.check_sample(rsp_tdata, rsp_tlast, rsp_tuser[0], rsp_tuser[2:1]);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("[adpcm_block_decoder_top] ERROR");
         $finish;
      end
   end

endmodule
